/* rtl/core/vdu_pkg.sv */
// ----------------------------------------------------------------------------
// vdu_pkg: shared definitions of the vector distance unit
// Field widths and the control group that the sequencer drives into the
// accumulator.
// ----------------------------------------------------------------------------
package vdu_pkg;

    localparam int EL_W       = 16;
    localparam int DIFF_W     = 17;
    localparam int SQ_TERM_W  = 32;
    localparam int SQ_W       = 44;
    localparam int ABS_W      = 26;
    localparam int ROOT_W     = 22;
    localparam int REM_W      = 24;
    localparam int ROOT_STEPS = 22;
    localparam int STEP_CNT_W = 5;

    typedef struct packed {
        logic capture;
        logic square;
        logic add;
        logic clear;
    } acc_ctrl_t;

endpackage

/* rtl/core/vector_distance_unit_core.sv */
// ----------------------------------------------------------------------------
// vector_distance_unit_core: Euclidean and Manhattan distance of two vectors
//
//   channel  direction  handshake           payload
//   in       to core    in_valid/in_ready   x_element, y_element, last
//   out      from core  out_valid/out_ready euclidean_distance, manhattan_distance
//
// An element pair passes through capture of the difference, one multiply and
// one saturating add, in that order through the accumulator.
// For the pair marked last, a load step then starts the square root and clears
// both sums; the square root produces one bit per cycle in a shared compare and
// subtract unit, and the result then moves into the output register.
// Reset clears both sums and the sequencer. A result that is not taken holds
// the root stage until the output register is free.
// ----------------------------------------------------------------------------
module vector_distance_unit_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [vdu_pkg::EL_W-1:0]   x_element,
    input  logic signed [vdu_pkg::EL_W-1:0]   y_element,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic        [vdu_pkg::ROOT_W-1:0] euclidean_distance,
    output logic        [vdu_pkg::ABS_W-1:0]  manhattan_distance
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_ROOT = 3'd4;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic                        last_reg;
    logic                        last_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [vdu_pkg::ROOT_W-1:0]  euc_reg;
    logic [vdu_pkg::ROOT_W-1:0]  euc_next;
    logic [vdu_pkg::ABS_W-1:0]   man_reg;
    logic [vdu_pkg::ABS_W-1:0]   man_next;
    logic [vdu_pkg::ABS_W-1:0]   man_hold_reg;
    logic [vdu_pkg::ABS_W-1:0]   man_hold_next;
    vdu_pkg::acc_ctrl_t          acc_ctrl;
    logic                        root_start;
    logic                        root_busy;
    logic [vdu_pkg::ROOT_W-1:0]  root_value;
    logic [vdu_pkg::SQ_W-1:0]    square_sum;
    logic [vdu_pkg::ABS_W-1:0]   absolute_sum;
    logic                        accept;
    logic                        out_free;

    vdu_accum u_accum
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (acc_ctrl),
        .x_element    (x_element),
        .y_element    (y_element),
        .square_sum   (square_sum),
        .absolute_sum (absolute_sum)
    );

    vdu_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (square_sum),
        .busy     (root_busy),
        .root     (root_value)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        last_next = last_reg;
        man_hold_next = man_hold_reg;
        euc_next = euc_reg;
        man_next = man_reg;
        out_valid_next = out_valid_reg && !out_ready;
        acc_ctrl = '0;
        root_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    acc_ctrl.capture = 1'b1;
                    last_next = last;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                acc_ctrl.square = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_ctrl.add = 1'b1;
                state_next = last_reg ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD:
            begin
                root_start = 1'b1;
                acc_ctrl.clear = 1'b1;
                man_hold_next = absolute_sum;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (!root_busy && out_free)
                begin
                    euc_next = root_value;
                    man_next = man_hold_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        man_hold_reg <= man_hold_next;
        euc_reg <= euc_next;
        man_reg <= man_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign euclidean_distance = euc_reg;
    assign manhattan_distance = man_reg;

endmodule

/* rtl/core/vdu_accum.sv */
// ----------------------------------------------------------------------------
// vdu_accum: difference, square and saturating running sums
// Registers the absolute difference of an element pair, squares it in a
// following cycle and adds both terms into saturating sums.
// ----------------------------------------------------------------------------
module vdu_accum
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  vdu_pkg::acc_ctrl_t                ctrl,
    input  logic signed [vdu_pkg::EL_W-1:0]   x_element,
    input  logic signed [vdu_pkg::EL_W-1:0]   y_element,
    output logic        [vdu_pkg::SQ_W-1:0]   square_sum,
    output logic        [vdu_pkg::ABS_W-1:0]  absolute_sum
);

    logic        [vdu_pkg::DIFF_W-1:0]      ad_reg;
    logic        [vdu_pkg::DIFF_W-1:0]      ad_next;
    logic        [vdu_pkg::SQ_TERM_W-1:0]   sq_reg;
    logic        [vdu_pkg::SQ_TERM_W-1:0]   sq_next;
    logic        [vdu_pkg::SQ_W-1:0]        square_sum_reg;
    logic        [vdu_pkg::SQ_W-1:0]        square_sum_next;
    logic        [vdu_pkg::ABS_W-1:0]       absolute_sum_reg;
    logic        [vdu_pkg::ABS_W-1:0]       absolute_sum_next;
    logic signed [vdu_pkg::DIFF_W-1:0]      diff;
    logic        [2*vdu_pkg::DIFF_W-1:0]    prod;
    logic        [vdu_pkg::SQ_W:0]          sq_total;
    logic        [vdu_pkg::ABS_W:0]         abs_total;

    always_comb
    begin
        diff = {x_element[vdu_pkg::EL_W-1], x_element}
             - {y_element[vdu_pkg::EL_W-1], y_element};
        ad_next = diff[vdu_pkg::DIFF_W-1] ? vdu_pkg::DIFF_W'(-diff) : diff;
        prod = ad_reg * ad_reg;
        sq_next = prod[vdu_pkg::SQ_TERM_W-1:0];
        sq_total = {1'b0, square_sum_reg}
                 + {{(vdu_pkg::SQ_W + 1 - vdu_pkg::SQ_TERM_W){1'b0}}, sq_reg};
        abs_total = {1'b0, absolute_sum_reg}
                  + {{(vdu_pkg::ABS_W + 1 - vdu_pkg::DIFF_W){1'b0}}, ad_reg};
        square_sum_next = square_sum_reg;
        absolute_sum_next = absolute_sum_reg;
        if (ctrl.clear)
        begin
            square_sum_next = '0;
            absolute_sum_next = '0;
        end
        else if (ctrl.add)
        begin
            square_sum_next = sq_total[vdu_pkg::SQ_W] ? '1
                            : sq_total[vdu_pkg::SQ_W-1:0];
            absolute_sum_next = abs_total[vdu_pkg::ABS_W] ? '1
                              : abs_total[vdu_pkg::ABS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            ad_reg <= ad_next;
        end
        if (ctrl.square)
        begin
            sq_reg <= sq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_sum_reg <= '0;
            absolute_sum_reg <= '0;
        end
        else
        begin
            square_sum_reg <= square_sum_next;
            absolute_sum_reg <= absolute_sum_next;
        end
    end

    assign square_sum = square_sum_reg;
    assign absolute_sum = absolute_sum_reg;

endmodule

/* rtl/core/vdu_isqrt.sv */
// ----------------------------------------------------------------------------
// vdu_isqrt: iterative floor square root
// Digit-by-digit restoring square root, one root bit per cycle through a
// single compare and subtract.
// ----------------------------------------------------------------------------
module vdu_isqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vdu_pkg::SQ_W-1:0]      radicand,
    output logic                          busy,
    output logic [vdu_pkg::ROOT_W-1:0]    root
);

    logic [vdu_pkg::SQ_W-1:0]        rad_reg;
    logic [vdu_pkg::SQ_W-1:0]        rad_next;
    logic [vdu_pkg::REM_W-1:0]       rem_reg;
    logic [vdu_pkg::REM_W-1:0]       rem_next;
    logic [vdu_pkg::ROOT_W-1:0]      root_reg;
    logic [vdu_pkg::ROOT_W-1:0]      root_next;
    logic [vdu_pkg::STEP_CNT_W-1:0]  count_reg;
    logic [vdu_pkg::STEP_CNT_W-1:0]  count_next;
    logic [vdu_pkg::REM_W-1:0]       rem_shift;
    logic [vdu_pkg::REM_W-1:0]       trial;

    always_comb
    begin
        rem_shift = {rem_reg[vdu_pkg::REM_W-3:0], rad_reg[vdu_pkg::SQ_W-1 -: 2]};
        trial = {root_reg, 2'b01};
        rad_next = rad_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        count_next = count_reg;
        if (start)
        begin
            rad_next = radicand;
            rem_next = '0;
            root_next = '0;
            count_next = vdu_pkg::STEP_CNT_W'(vdu_pkg::ROOT_STEPS);
        end
        else if (count_reg != '0)
        begin
            rad_next = {rad_reg[vdu_pkg::SQ_W-3:0], 2'b00};
            count_next = count_reg - 1'b1;
            if (rem_shift >= trial)
            begin
                rem_next = rem_shift - trial;
                root_next = {root_reg[vdu_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                root_next = {root_reg[vdu_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign busy = (count_reg != '0);
    assign root = root_reg;

endmodule

/* sim/vector_distance_unit_core_test.sv */
// ----------------------------------------------------------------------------
// vector_distance_unit_core_test: self-checking bench for the distance core
// Streams element pairs of two vectors into the core and works out the
// Euclidean and Manhattan distance of each vector in a model of its own. The
// results that the core returns are compared with these, oldest first. Both
// sides idle at random, the receiver holds off once for a long stretch, and
// a long vector drives the absolute sum into saturation.
// ----------------------------------------------------------------------------
module vector_distance_unit_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import vdu_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 683;
    localparam int LONG_HOLD      = 500;
    localparam int HOLD_AT_RESULT = 8;
    localparam int DRAIN_CYCLES   = 40;
    localparam int IDLE_LIMIT     = 4000;

    localparam logic signed [EL_W-1:0] EL_MAX  = 16'sh7FFF;
    localparam logic signed [EL_W-1:0] EL_MIN  = 16'sh8000;
    localparam logic        [SQ_W-1:0] SQ_TOP  = {SQ_W{1'b1}};
    localparam logic        [ABS_W-1:0] ABS_TOP = {ABS_W{1'b1}};

    typedef struct packed {
        logic signed [EL_W-1:0] x;
        logic signed [EL_W-1:0] y;
        logic                   last;
    } pair_t;

    typedef struct packed {
        logic [ROOT_W-1:0] euclid;
        logic [ABS_W-1:0]  manhattan;
    } distance_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic signed [EL_W-1:0] x_element = '0;
    logic signed [EL_W-1:0] y_element = '0;
    logic                   last = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [ROOT_W-1:0]      euclidean_distance;
    logic [ABS_W-1:0]       manhattan_distance;

    pair_t       pending_pairs[$];
    distance_t   pending_distances[$];
    pair_t       current_pair;
    logic [SQ_W-1:0]  square_acc = '0;
    logic [ABS_W-1:0] abs_acc = '0;
    int unsigned send_wait;
    int unsigned recv_wait;
    int unsigned sender_lull;
    int unsigned receiver_lull;
    int unsigned distances_taken;
    int unsigned idle_cycles;
    int unsigned mismatches;
    bit          long_hold_done;

    vector_distance_unit_core dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .x_element          (x_element),
        .y_element          (y_element),
        .last               (last),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .euclidean_distance (euclidean_distance),
        .manhattan_distance (manhattan_distance)
    );

    always #2 clk = ~clk;

    function automatic logic [ROOT_W-1:0] floor_root(input logic [SQ_W-1:0] v);
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] trial;
        logic [SQ_W-1:0]   trial_sq;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (ROOT_W'(1) << b);
            trial_sq = SQ_W'(trial) * SQ_W'(trial);
            if (trial_sq <= v)
                root = trial;
        end
        return root;
    endfunction

    task automatic accumulate_pair(input pair_t p);
        logic signed [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0]        mag;
        logic [SQ_W:0]            sq_next;
        logic [ABS_W:0]           abs_next;
        distance_t                d;
        diff = {p.x[EL_W-1], p.x} - {p.y[EL_W-1], p.y};
        mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        sq_next = (SQ_W+1)'(square_acc) + (SQ_W+1)'(mag) * (SQ_W+1)'(mag);
        abs_next = (ABS_W+1)'(abs_acc) + (ABS_W+1)'(mag);
        square_acc = (sq_next > (SQ_W+1)'(SQ_TOP)) ? SQ_TOP : sq_next[SQ_W-1:0];
        abs_acc = (abs_next > (ABS_W+1)'(ABS_TOP)) ? ABS_TOP : abs_next[ABS_W-1:0];
        if (p.last)
        begin
            d.euclid = floor_root(square_acc);
            d.manhattan = abs_acc;
            pending_distances.push_back(d);
            square_acc = '0;
            abs_acc = '0;
        end
    endtask

    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Now and then a side runs a stretch of items with no idling at all.
    function automatic int unsigned gap_with_lulls(ref int unsigned lull);
        if (lull > 0)
        begin
            lull--;
            return 0;
        end
        if ($urandom_range(0, 99) < 3)
            lull = $urandom_range(30, 150);
        return idle_span();
    endfunction

    function automatic logic signed [EL_W-1:0] pick_element();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return EL_W'($urandom);
        if (r < 7)
        begin
            case ($urandom_range(0, 3))
                0: return EL_MAX;
                1: return EL_MIN;
                2: return '0;
                default: return -16'sd1;
            endcase
        end
        return EL_W'($urandom_range(0, 64)) - 16'sd32;
    endfunction

    task automatic add_pair(input logic signed [EL_W-1:0] x,
                            input logic signed [EL_W-1:0] y,
                            input logic last_flag);
        pair_t p;
        p.x = x;
        p.y = y;
        p.last = last_flag;
        pending_pairs.push_back(p);
    endtask

    // Sender: offers the queued pairs, feeding each accepted one to the model.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            x_element <= '0;
            y_element <= '0;
            last <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                accumulate_pair(current_pair);
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    in_valid <= 1'b0;
                    send_wait--;
                end
                else if (pending_pairs.size() > 0)
                begin
                    current_pair = pending_pairs.pop_front();
                    x_element <= current_pair.x;
                    y_element <= current_pair.y;
                    last <= current_pair.last;
                    in_valid <= 1'b1;
                    send_wait = gap_with_lulls(sender_lull);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result and decides when to be ready again.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_distances.size() == 0)
                begin
                    $error("result arrived with no vector outstanding");
                    mismatches++;
                end
                else
                begin
                    distance_t want;
                    want = pending_distances.pop_front();
                    if (euclidean_distance !== want.euclid)
                    begin
                        $error("euclidean_distance: expected %0d, got %0d",
                               want.euclid, euclidean_distance);
                        mismatches++;
                    end
                    if (manhattan_distance !== want.manhattan)
                    begin
                        $error("manhattan_distance: expected %0d, got %0d",
                               want.manhattan, manhattan_distance);
                        mismatches++;
                    end
                end
                distances_taken++;
                if (!long_hold_done && distances_taken == HOLD_AT_RESULT)
                begin
                    recv_wait = LONG_HOLD;
                    long_hold_done = 1'b1;
                end
                else
                begin
                    recv_wait = gap_with_lulls(receiver_lull);
                end
            end
            else if (recv_wait == 0 && $urandom_range(0, 99) < 4)
            begin
                recv_wait = idle_span();
            end
            if (recv_wait > 0)
            begin
                out_ready <= 1'b0;
                recv_wait--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("vector_distance_unit_core test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned made;
        int unsigned len;
        int unsigned r;
        bit          flip;

        // Single-pair vectors at the extremes, then short hand-made vectors.
        add_pair(EL_MAX, EL_MIN, 1'b1);
        add_pair(EL_MIN, EL_MAX, 1'b1);
        add_pair('0, '0, 1'b1);
        add_pair(EL_MIN, EL_MIN, 1'b1);
        add_pair(EL_MAX, EL_MAX, 1'b1);
        add_pair(16'sd1, '0, 1'b0);
        add_pair('0, 16'sd1, 1'b0);
        add_pair(-16'sd1, '0, 1'b0);
        add_pair('0, -16'sd1, 1'b1);
        add_pair(16'sd16384, '0, 1'b0);
        add_pair('0, -16'sd16384, 1'b1);
        add_pair(-16'sd1, 16'sd1, 1'b1);
        add_pair(16'sh5555, 16'shAAAA, 1'b0);
        add_pair(16'shAAAA, 16'sh5555, 1'b0);
        add_pair(16'sh0F0F, 16'shF0F0, 1'b1);
        add_pair(16'sd3, 16'sd0, 1'b0);
        add_pair(16'sd0, 16'sd4, 1'b1);

        // Enough full-scale differences to pin the absolute sum at its top.
        for (int i = 0; i < 1100; i++)
        begin
            flip = i[0];
            add_pair(flip ? EL_MAX : EL_MIN, flip ? EL_MIN : EL_MAX, i == 1099);
        end

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 8);
            else if (r < 95)
                len = $urandom_range(9, 64);
            else
                len = $urandom_range(65, 300);
            if (len > RANDOM_ITEMS - made)
                len = RANDOM_ITEMS - made;
            for (int i = 0; i < len; i++)
                add_pair(pick_element(), pick_element(), i == len - 1);
            made += len;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_pairs.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("vector_distance_unit_core test passed");
        else
            $display("vector_distance_unit_core test failed");
        $finish;
    end

endmodule
